FILE: sv/lpmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpmd_pkg: shared types and constants of the message deframer
// Result word layout, event and error codes, parser phases.
// ----------------------------------------------------------------------------
package lpmd_pkg;

  localparam int unsigned LineIdxW   = 16;
  localparam int unsigned HdrBytes   = 4;
  localparam logic [31:0] MaxLenRst  = 32'd4091;

  typedef enum logic [2:0] {
    EvHdrByte = 3'd0,
    EvMsgHdr  = 3'd1,
    EvLineHdr = 3'd2,
    EvPayload = 3'd3,
    EvError   = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrTooLong = 2'd1,
    ErrOverrun = 2'd2
  } error_e;

  typedef enum logic [3:0] {
    PhType = 4'b0001,
    PhSize = 4'b0010,
    PhLhdr = 4'b0100,
    PhData = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [7:0]  message_type;
    logic [15:0] line_number;
    logic [31:0] line_len;
    logic        line_end;
    logic        message_end;
    logic [1:0]  error_code;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/lpmd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpmd_in_if: input byte channel
// Valid/ready channel carrying one stream byte per word.
// ----------------------------------------------------------------------------
interface lpmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface
`default_nettype wire

FILE: sv/lpmd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpmd_out_if: result channel
// Valid/ready channel carrying one deframer result per word.
// ----------------------------------------------------------------------------
interface lpmd_out_if;
  logic           valid;
  logic           ready;
  lpmd_pkg::res_t res;

  modport source (output valid, output res, input ready);
  modport sink   (input valid, input res, output ready);
endinterface
`default_nettype wire

FILE: sv/length_prefixed_message_deframer.sv
`default_nettype none
// A result is registered into the output buffer when its byte is accepted.
// Throughput: 1 byte per cycle; each byte takes one pass through the parser
// logic into a two-word output buffer, so input stalls only when both are full.
// Reset: async active low; parser waits for a type byte, max_len_q = 4091.
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer: length-prefixed message deframer
// Parses type, body size and length-prefixed lines; one result per byte.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  lpmd_in_if.sink          stream_i,
  lpmd_out_if.source       result_o
);

  localparam int unsigned IW = lpmd_pkg::LineIdxW;

  logic [31:0]       max_len_q;
  lpmd_pkg::phase_e  phase_q, phase_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [31:0]       shift_q, shift_d;
  logic [7:0]        type_q, type_d;
  logic [31:0]       body_q, body_d;
  logic [31:0]       line_left_q, line_left_d;
  logic [IW-1:0]     line_cnt_q, line_cnt_d;
  logic [31:0]       line_len_q, line_len_d;

  lpmd_pkg::res_t    main_q, skid_q, res_d;
  logic              main_vld_q, skid_vld_q;

  logic              acc, pop;
  logic [7:0]        b;
  logic [31:0]       shift_nx, body_dec, line_dec, shown_ext;
  logic [1:0]        cnt_nx;
  logic [IW-1:0]     line_cnt_inc, shown;
  logic              last_hdr;

  assign b        = stream_i.stream_byte;
  assign acc      = stream_i.valid && stream_i.ready;
  assign pop      = main_vld_q && result_o.ready;
  assign stream_i.ready = !skid_vld_q;
  assign result_o.valid = main_vld_q;
  assign result_o.res   = main_q;

  assign shift_nx = {shift_q[23:0], b};
  assign cnt_nx   = cnt_q + 2'd1;
  assign last_hdr = (cnt_q == 2'(lpmd_pkg::HdrBytes - 1));
  assign body_dec = body_q - 32'd1;
  assign line_dec = line_left_q - 32'd1;
  assign line_cnt_inc = (line_cnt_q != {IW{1'b1}}) ? line_cnt_q + {{(IW-1){1'b0}}, 1'b1}
                                                    : line_cnt_q;

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    shift_d     = shift_q;
    type_d      = type_q;
    body_d      = body_q;
    line_left_d = line_left_q;
    line_cnt_d  = line_cnt_q;
    line_len_d  = line_len_q;
    shown       = line_cnt_q;
    res_d             = '0;
    res_d.event_res   = lpmd_pkg::EvHdrByte;
    res_d.error_code  = lpmd_pkg::ErrNone;
    case (phase_q)
      lpmd_pkg::PhSize: begin
        shift_d = shift_nx;
        cnt_d   = cnt_nx;
        if (last_hdr) begin
          if (shift_nx > max_len_q) begin
            res_d.event_res  = lpmd_pkg::EvError;
            res_d.error_code = lpmd_pkg::ErrTooLong;
            phase_d          = lpmd_pkg::PhType;
          end else begin
            res_d.event_res = lpmd_pkg::EvMsgHdr;
            body_d          = shift_nx;
            if (shift_nx == 32'd0) begin
              res_d.message_end = 1'b1;
              phase_d           = lpmd_pkg::PhType;
            end else begin
              phase_d = lpmd_pkg::PhLhdr;
            end
          end
        end
      end
      lpmd_pkg::PhLhdr: begin
        if (cnt_q == 2'd0 && body_q < 32'(lpmd_pkg::HdrBytes)) begin
          res_d.event_res  = lpmd_pkg::EvError;
          res_d.error_code = lpmd_pkg::ErrOverrun;
          phase_d          = lpmd_pkg::PhType;
        end else begin
          shift_d = shift_nx;
          body_d  = body_dec;
          cnt_d   = cnt_nx;
          if (last_hdr) begin
            if (shift_nx > body_dec) begin
              res_d.event_res  = lpmd_pkg::EvError;
              res_d.error_code = lpmd_pkg::ErrOverrun;
              phase_d          = lpmd_pkg::PhType;
            end else begin
              res_d.event_res = lpmd_pkg::EvLineHdr;
              line_len_d      = shift_nx;
              line_left_d     = shift_nx;
              if (shift_nx == 32'd0) begin
                res_d.line_end = 1'b1;
                line_cnt_d     = line_cnt_inc;
                if (body_dec == 32'd0) begin
                  res_d.message_end = 1'b1;
                  phase_d           = lpmd_pkg::PhType;
                end
              end else begin
                phase_d = lpmd_pkg::PhData;
              end
            end
          end
        end
      end
      lpmd_pkg::PhData: begin
        res_d.event_res = lpmd_pkg::EvPayload;
        res_d.data_byte = b;
        line_left_d     = line_dec;
        body_d          = body_dec;
        if (line_dec == 32'd0) begin
          res_d.line_end = 1'b1;
          line_cnt_d     = line_cnt_inc;
          if (body_dec == 32'd0) begin
            res_d.message_end = 1'b1;
            phase_d           = lpmd_pkg::PhType;
          end else begin
            phase_d = lpmd_pkg::PhLhdr;
          end
        end
      end
      default: begin
        type_d      = b;
        line_cnt_d  = '0;
        line_len_d  = '0;
        line_left_d = '0;
        body_d      = '0;
        shift_d     = '0;
        cnt_d       = '0;
        shown       = '0;
        phase_d     = lpmd_pkg::PhSize;
      end
    endcase
    shown_ext          = 32'(shown);
    res_d.message_type = type_d;
    res_d.line_len     = line_len_d;
    res_d.line_number  = shown_ext[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= lpmd_pkg::MaxLenRst;
      phase_q     <= lpmd_pkg::PhType;
      cnt_q       <= '0;
      shift_q     <= '0;
      type_q      <= '0;
      body_q      <= '0;
      line_left_q <= '0;
      line_cnt_q  <= '0;
      line_len_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (acc) begin
        phase_q     <= phase_d;
        cnt_q       <= cnt_d;
        shift_q     <= shift_d;
        type_q      <= type_d;
        body_q      <= body_d;
        line_left_q <= line_left_d;
        line_cnt_q  <= line_cnt_d;
        line_len_q  <= line_len_d;
      end
    end
  end

  // output buffer: main word plus skid word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (main_vld_q) begin
      if (!pop && acc) begin
        skid_vld_q <= 1'b1;
      end else if (pop && !acc) begin
        main_vld_q <= 1'b0;
      end
    end else if (acc) begin
      main_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (acc) begin
      if (main_vld_q && !pop) begin
        skid_q <= res_d;
      end else begin
        main_q <= res_d;
      end
    end
  end

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> main_vld_q)
    else $error("skid word held without main word");

  a_err_code_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    main_vld_q |-> ((main_q.event_res == lpmd_pkg::EvError) ==
                    (main_q.error_code != lpmd_pkg::ErrNone)))
    else $error("error code and event disagree");

  a_msg_end_resync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (res_d.message_end || res_d.event_res == lpmd_pkg::EvError))
    |=> phase_q == lpmd_pkg::PhType)
    else $error("parser did not return to type phase");

  a_data_only_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_vld_q && main_q.event_res != lpmd_pkg::EvPayload) |-> main_q.data_byte == 8'd0)
    else $error("data byte outside payload event");

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register not one-hot");

endmodule
`default_nettype wire

FILE: tb/sv/length_prefixed_message_deframer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_test: self-checking bench for the deframer
// Sends directed and random framed messages, noise and broken frames with
// random stalls on both channels, and compares each result word field by
// field with a predicted one.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer_test;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned PhaseBytes    = 230;
  localparam logic [31:0] LineIdxMax    = 32'((64'd1 << lpmd_pkg::LineIdxW) - 64'd1);

  typedef struct {
    logic [7:0]     stream_byte;
    bit             typed;
    lpmd_pkg::res_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  lpmd_in_if  stream_ch();
  lpmd_out_if result_ch();

  length_prefixed_message_deframer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stream_i    (stream_ch),
    .result_o    (result_ch)
  );

  lpmd_pkg::phase_e frame_phase;
  logic [1:0]  hdr_count;
  logic [31:0] len_acc;
  logic [7:0]  msg_type;
  logic [31:0] body_rem;
  logic [31:0] line_rem;
  logic [31:0] line_idx;
  logic [31:0] line_len_cur;
  logic [31:0] body_limit;

  lpmd_pkg::res_t due_results[$];
  logic [7:0]  msg_bytes[$];
  bit          row_typed;
  lpmd_pkg::res_t row_want;
  bit          no_idle;
  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void bump_line();
    if (line_idx < LineIdxMax) line_idx = line_idx + 32'd1;
  endfunction

  function automatic lpmd_pkg::res_t deframe_byte(input logic [7:0] b);
    lpmd_pkg::res_t r;
    logic [31:0]    shown;
    r = '0;
    shown = line_idx;
    case (frame_phase)
      lpmd_pkg::PhSize: begin
        len_acc = {len_acc[23:0], b};
        hdr_count = hdr_count + 2'd1;
        if (hdr_count == 2'd0) begin
          if (len_acc > body_limit) begin
            r.event_res = lpmd_pkg::EvError;
            r.error_code = lpmd_pkg::ErrTooLong;
            frame_phase = lpmd_pkg::PhType;
          end else begin
            r.event_res = lpmd_pkg::EvMsgHdr;
            body_rem = len_acc;
            if (body_rem == 32'd0) begin
              r.message_end = 1'b1;
              frame_phase = lpmd_pkg::PhType;
            end else begin
              frame_phase = lpmd_pkg::PhLhdr;
            end
          end
        end
      end
      lpmd_pkg::PhLhdr: begin
        if (hdr_count == 2'd0 && body_rem < lpmd_pkg::HdrBytes) begin
          r.event_res = lpmd_pkg::EvError;
          r.error_code = lpmd_pkg::ErrOverrun;
          frame_phase = lpmd_pkg::PhType;
        end else begin
          len_acc = {len_acc[23:0], b};
          body_rem = body_rem - 32'd1;
          hdr_count = hdr_count + 2'd1;
          if (hdr_count == 2'd0) begin
            if (len_acc > body_rem) begin
              r.event_res = lpmd_pkg::EvError;
              r.error_code = lpmd_pkg::ErrOverrun;
              frame_phase = lpmd_pkg::PhType;
            end else begin
              r.event_res = lpmd_pkg::EvLineHdr;
              line_len_cur = len_acc;
              line_rem = len_acc;
              if (line_rem == 32'd0) begin
                r.line_end = 1'b1;
                bump_line();
                if (body_rem == 32'd0) begin
                  r.message_end = 1'b1;
                  frame_phase = lpmd_pkg::PhType;
                end
              end else begin
                frame_phase = lpmd_pkg::PhData;
              end
            end
          end
        end
      end
      lpmd_pkg::PhData: begin
        r.event_res = lpmd_pkg::EvPayload;
        r.data_byte = b;
        line_rem = line_rem - 32'd1;
        body_rem = body_rem - 32'd1;
        if (line_rem == 32'd0) begin
          r.line_end = 1'b1;
          bump_line();
          if (body_rem == 32'd0) begin
            r.message_end = 1'b1;
            frame_phase = lpmd_pkg::PhType;
          end else begin
            frame_phase = lpmd_pkg::PhLhdr;
          end
        end
      end
      default: begin
        msg_type = b;
        line_idx = '0;
        line_len_cur = '0;
        line_rem = '0;
        body_rem = '0;
        len_acc = '0;
        hdr_count = '0;
        shown = '0;
        frame_phase = lpmd_pkg::PhSize;
      end
    endcase
    r.message_type = msg_type;
    r.line_number = shown[15:0];
    r.line_len = line_len_cur;
    return r;
  endfunction

  function automatic lpmd_pkg::res_t res_of(input lpmd_pkg::event_e ev,
                                            input logic [7:0] typ,
                                            input logic [15:0] idx,
                                            input logic [31:0] len,
                                            input logic mend,
                                            input lpmd_pkg::error_e err);
    lpmd_pkg::res_t r;
    r = '0;
    r.event_res = ev;
    r.message_type = typ;
    r.line_number = idx;
    r.line_len = len;
    r.message_end = mend;
    r.error_code = err;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    bit             moved;
    lpmd_pkg::res_t want;
    lpmd_pkg::res_t got;
    moved = 1'b0;
    if (!rst_ni) begin
      frame_phase = lpmd_pkg::PhType;
      hdr_count = '0;
      len_acc = '0;
      msg_type = '0;
      body_rem = '0;
      line_rem = '0;
      line_idx = '0;
      line_len_cur = '0;
      body_limit = lpmd_pkg::MaxLenRst;
      idle_cycles = 0;
    end else begin
      if (cfg_we_i) body_limit = cfg_wdata_i;
      if (stream_ch.valid && stream_ch.ready) begin
        moved = 1'b1;
        want = deframe_byte(stream_ch.stream_byte);
        if (row_typed) want = row_want;
        due_results.push_back(want);
      end
      if (result_ch.valid && result_ch.ready) begin
        moved = 1'b1;
        got = result_ch.res;
        if (due_results.size() == 0) begin
          $error("result word with no byte pending");
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("event_res", want.event_res, got.event_res);
          check_field("data_byte", want.data_byte, got.data_byte);
          check_field("message_type", want.message_type, got.message_type);
          check_field("line_number", want.line_number, got.line_number);
          check_field("line_len", want.line_len, got.line_len);
          check_field("line_end", want.line_end, got.line_end);
          check_field("message_end", want.message_end, got.message_end);
          check_field("error_code", want.error_code, got.error_code);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    int unsigned stall;
    result_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input lpmd_pkg::res_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      stream_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    stream_ch.valid <= 1'b1;
    stream_ch.stream_byte <= b;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk_i);
    while (!stream_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    stream_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // feed zeros until the parser waits for a type byte again
  task automatic settle_parser();
    drain_results();
    while (frame_phase != lpmd_pkg::PhType) begin
      send_byte(8'h00, 1'b0, '0);
      drain_results();
    end
  endtask

  task automatic write_limit(input logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic build_message(input bit clean);
    logic [7:0]  body[$];
    logic [31:0] size;
    logic [31:0] len;
    int unsigned lines;
    int unsigned flavor;
    lines = $urandom_range(0, 4);
    repeat (lines) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      body.push_back(len[31:24]);
      body.push_back(len[23:16]);
      body.push_back(len[15:8]);
      body.push_back(len[7:0]);
      repeat (len) body.push_back(8'($urandom_range(0, 255)));
    end
    size = body.size();
    flavor = clean ? 0 : $urandom_range(0, 9);
    case (flavor)
      6: size = size + $urandom_range(1, 3);
      7: if (size > 3) size = size - $urandom_range(1, 3);
      8: if (lines != 0) body[3] = 8'($urandom_range(0, 255));
      9: size = $urandom();
      default: ;
    endcase
    msg_bytes.delete();
    msg_bytes.push_back(8'($urandom_range(0, 255)));
    msg_bytes.push_back(size[31:24]);
    msg_bytes.push_back(size[23:16]);
    msg_bytes.push_back(size[15:8]);
    msg_bytes.push_back(size[7:0]);
    foreach (body[k]) msg_bytes.push_back(body[k]);
  endtask

  initial begin
    stim_row_t   dir_rows[$];
    logic [31:0] limits[$];
    int unsigned sent;
    bit          clean;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    stream_ch.valid = 1'b0;
    stream_ch.stream_byte = '0;
    row_typed = 1'b0;
    row_want = '0;
    no_idle = 1'b0;

    dir_rows = '{
      '{8'hFF, 1, res_of(lpmd_pkg::EvHdrByte, 8'hFF, 16'd0, 32'd0, 1'b0,
                         lpmd_pkg::ErrNone)},
      '{8'h00, 0, '0}, '{8'h00, 0, '0}, '{8'h0F, 0, '0},
      '{8'hFC, 1, res_of(lpmd_pkg::EvError, 8'hFF, 16'd0, 32'd0, 1'b0,
                         lpmd_pkg::ErrTooLong)},
      '{8'h00, 0, '0},
      '{8'h00, 0, '0}, '{8'h00, 0, '0}, '{8'h00, 0, '0},
      '{8'h00, 1, res_of(lpmd_pkg::EvMsgHdr, 8'h00, 16'd0, 32'd0, 1'b1,
                         lpmd_pkg::ErrNone)},
      '{8'h80, 0, '0},
      '{8'h00, 0, '0}, '{8'h00, 0, '0}, '{8'h00, 0, '0}, '{8'h0A, 0, '0},
      '{8'h00, 0, '0}, '{8'h00, 0, '0}, '{8'h00, 0, '0}, '{8'h00, 0, '0},
      '{8'h00, 0, '0}, '{8'h00, 0, '0}, '{8'h00, 0, '0}, '{8'h01, 0, '0},
      '{8'hFF, 0, '0},
      '{8'h5A, 1, res_of(lpmd_pkg::EvError, 8'h80, 16'd2, 32'd1, 1'b0,
                         lpmd_pkg::ErrOverrun)},
      '{8'h01, 0, '0},
      '{8'h00, 0, '0}, '{8'h00, 0, '0}, '{8'h00, 0, '0}, '{8'h05, 0, '0},
      '{8'h00, 0, '0}, '{8'h00, 0, '0}, '{8'h00, 0, '0},
      '{8'h02, 1, res_of(lpmd_pkg::EvError, 8'h01, 16'd0, 32'd0, 1'b0,
                         lpmd_pkg::ErrOverrun)}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].stream_byte, dir_rows[i].typed, dir_rows[i].want);
    end

    limits = '{lpmd_pkg::MaxLenRst, 32'd0, 32'hFFFF_FFFF, $urandom_range(8, 48),
               $urandom(), lpmd_pkg::MaxLenRst, $urandom_range(0, 24)};
    foreach (limits[p]) begin
      if (p != 0) begin
        settle_parser();
        write_limit(limits[p]);
      end
      sent = 0;
      clean = (limits[p] >= 32'h0001_0000);
      while (sent < PhaseBytes) begin
        no_idle = ($urandom_range(0, 7) == 0);
        if (!clean && $urandom_range(0, 11) == 0) begin
          repeat ($urandom_range(1, 6)) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            sent++;
          end
        end else begin
          build_message(clean);
          foreach (msg_bytes[k]) send_byte(msg_bytes[k], 1'b0, '0);
          sent += msg_bytes.size();
        end
        if ($urandom_range(0, 24) == 0) drain_results();
      end
    end

    no_idle = 1'b0;
    drain_results();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
